[sv/acsg_pkg.sv]
// ----------------------------------------------------------------------------
// acsg_pkg
// Shared types, constants and helper functions for the cursor sequence
// generator. These include the decimal place table, the command and status
// structs, and the byte selector codes.
// ----------------------------------------------------------------------------
package acsg_pkg;

  // Decimal converter size
  localparam int PLACE_COUNT = 10;
  localparam int MAX_DIGITS  = 10;
  localparam int DIGITS_USED = (MAX_DIGITS < 1) ? 1 :
                               ((MAX_DIGITS > PLACE_COUNT) ? PLACE_COUNT : MAX_DIGITS);
  localparam int FIRST_PLACE = PLACE_COUNT - DIGITS_USED;
  localparam int IDX_W       = $clog2(PLACE_COUNT);
  localparam int VAL_W       = 32;
  localparam int MULT_W      = VAL_W + 2;

  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(FIRST_PLACE);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(PLACE_COUNT - 1);

  // Character codes
  localparam logic [6:0] CH_ESC  = 7'h1B;
  localparam logic [6:0] CH_LBR  = 7'h5B;
  localparam logic [6:0] CH_SEMI = 7'h3B;
  localparam logic [6:0] CH_H    = 7'h48;
  localparam logic [6:0] CH_ZERO = 7'h30;

  // Power of ten for a place, most significant place first
  function automatic logic [VAL_W-1:0] place_value(input logic [IDX_W-1:0] idx);
    logic [VAL_W-1:0] p;
    case (idx)
      4'd0:    p = 32'd1000000000;
      4'd1:    p = 32'd100000000;
      4'd2:    p = 32'd10000000;
      4'd3:    p = 32'd1000000;
      4'd4:    p = 32'd100000;
      4'd5:    p = 32'd10000;
      4'd6:    p = 32'd1000;
      4'd7:    p = 32'd100;
      4'd8:    p = 32'd10;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

  // Multiple k of a place value, wide enough for 9 * 10^9
  function automatic logic [MULT_W-1:0] place_mult(input logic [IDX_W-1:0] idx,
                                                   input logic [3:0]       k);
    return MULT_W'(place_value(idx)) * MULT_W'(k);
  endfunction

  // Largest value that fits in the converter
  localparam logic [VAL_W-1:0] SAT_LIMIT = (FIRST_PLACE > 0) ?
      place_value(IDX_W'(FIRST_PLACE - 1)) - VAL_W'(1) : {VAL_W{1'b1}};

  // Source of the next output word
  typedef enum logic [2:0] {
    SEL_ESC,
    SEL_LBR,
    SEL_DIGIT,
    SEL_SEMI,
    SEL_H
  } byte_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic      accept;
    logic      load_col;
    logic      step;
    logic      push;
    byte_sel_e sel;
  } acsg_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic digit_emit;
    logic last_place;
  } acsg_status_t;

endpackage

[sv/ansi_cursor_sequence_generator_top.sv]
// The first word (ESC) is pushed into the output register from the ESC state, which
//   follows the state in which the input word is taken. At most one output word per cycle,
//   while the output register is free; the converter steps through every decimal place
//   whether or not it prints, and takes a new item only after the last H word is pushed.
// Reset: rst_ni clears the controller and the output valid; no item is held.
// ----------------------------------------------------------------------------
// ansi_cursor_sequence_generator_top
// Turns a row and column pair into the terminal cursor-position sequence
// ESC [ row ; column H, one character per output word.
// ----------------------------------------------------------------------------
module ansi_cursor_sequence_generator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] row, [63:32] column
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [6:0] out_byte, [7] zero
  output logic        m_axis_tlast_o    // last
);
  import acsg_pkg::*;

  acsg_cmd_t    cmd;
  acsg_status_t status;

  acsg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  acsg_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (s_axis_tdata_i),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tlast_o  (m_axis_tlast_o)
  );

endmodule

[sv/acsg_dp.sv]
// ----------------------------------------------------------------------------
// acsg_dp
// Datapath: holds the numbers, converts one decimal place per step through
// a row of parallel compares against the place multiples, and drives the
// output word register.
// ----------------------------------------------------------------------------
module acsg_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  acsg_pkg::acsg_cmd_t  cmd_i,
  output acsg_pkg::acsg_status_t status_o,
  input  logic [63:0]          in_data_i,
  input  logic                 m_tready_i,
  output logic                 m_tvalid_o,
  output logic [7:0]           m_tdata_o,
  output logic                 m_tlast_o
);
  import acsg_pkg::*;

  logic [VAL_W-1:0] col_q, col_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             begun_q, begun_d;
  logic             m_tvalid_q, m_tvalid_d;
  logic [6:0]       byte_q, byte_d;
  logic             last_q, last_d;

  logic [8:0]        ge;
  logic [3:0]        digit;
  logic [MULT_W-1:0] sub_amt;
  logic [VAL_W-1:0]  remain;
  logic [6:0]        char;

  // Clamp a number to the converter range
  function automatic logic [VAL_W-1:0] sat(input logic [VAL_W-1:0] v);
    return (v > SAT_LIMIT) ? SAT_LIMIT : v;
  endfunction

  // Digit of the current place: count the multiples not above the value
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      ge[k] = {2'b00, val_q} >= place_mult(idx_q, 4'(k + 1));
    end
    digit   = 4'($countones(ge));
    sub_amt = place_mult(idx_q, digit);
    remain  = val_q - sub_amt[VAL_W-1:0];
  end

  assign status_o.digit_emit = (digit != 4'd0) || begun_q || (idx_q == LAST_IDX);
  assign status_o.last_place = (idx_q == LAST_IDX);
  assign status_o.out_free   = !m_tvalid_q || m_tready_i;

  // Pick the character for the next word
  always_comb begin
    case (cmd_i.sel)
      SEL_ESC:   char = CH_ESC;
      SEL_LBR:   char = CH_LBR;
      SEL_DIGIT: char = CH_ZERO + {3'b000, digit};
      SEL_SEMI:  char = CH_SEMI;
      SEL_H:     char = CH_H;
      default:   char = CH_ESC;
    endcase
  end

  // Next values of the number registers
  always_comb begin
    col_d   = col_q;
    val_d   = val_q;
    idx_d   = idx_q;
    begun_d = begun_q;
    if (cmd_i.accept) begin
      val_d   = sat(in_data_i[31:0]);
      col_d   = sat(in_data_i[63:32]);
      idx_d   = FIRST_IDX;
      begun_d = 1'b0;
    end else if (cmd_i.load_col) begin
      val_d   = col_q;
      idx_d   = FIRST_IDX;
      begun_d = 1'b0;
    end else if (cmd_i.step) begin
      val_d   = remain;
      idx_d   = (idx_q == LAST_IDX) ? idx_q : idx_q + IDX_W'(1);
      begun_d = status_o.digit_emit;
    end
  end

  // Output word register
  always_comb begin
    byte_d     = byte_q;
    last_d     = last_q;
    m_tvalid_d = m_tvalid_q && !m_tready_i;
    if (cmd_i.push) begin
      byte_d     = char;
      last_d     = (cmd_i.sel == SEL_H);
      m_tvalid_d = 1'b1;
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
      begun_q    <= 1'b0;
      idx_q      <= FIRST_IDX;
    end else begin
      m_tvalid_q <= m_tvalid_d;
      begun_q    <= begun_d;
      idx_q      <= idx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    col_q  <= col_d;
    val_q  <= val_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = {1'b0, byte_q};
  assign m_tlast_o  = last_q;

endmodule

[sv/acsg_ctrl.sv]
// ----------------------------------------------------------------------------
// acsg_ctrl
// Controller: walks through the fields of the sequence and, for each free
// slot in the output register, issues a push, a datapath step, or both.
// ----------------------------------------------------------------------------
module acsg_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  output logic                   s_tready_o,
  input  acsg_pkg::acsg_status_t status_i,
  output acsg_pkg::acsg_cmd_t    cmd_o
);
  import acsg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ESC,
    ST_LBR,
    ST_ROW,
    ST_SEMI,
    ST_COL,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   free;

  assign free       = status_i.out_free;
  assign s_tready_o = (state_q == ST_IDLE);

  // Decode commands and next state
  always_comb begin
    state_d      = state_q;
    cmd_o.accept   = 1'b0;
    cmd_o.load_col = 1'b0;
    cmd_o.step     = 1'b0;
    cmd_o.push     = 1'b0;
    cmd_o.sel      = SEL_DIGIT;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_ESC;
        end
      end
      ST_ESC: begin
        cmd_o.sel = SEL_ESC;
        if (free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_LBR;
        end
      end
      ST_LBR: begin
        cmd_o.sel = SEL_LBR;
        if (free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_ROW;
        end
      end
      ST_ROW, ST_COL: begin
        cmd_o.sel = SEL_DIGIT;
        if (free) begin
          cmd_o.step = 1'b1;
          cmd_o.push = status_i.digit_emit;
          if (status_i.last_place) begin
            state_d = (state_q == ST_ROW) ? ST_SEMI : ST_FIN;
          end
        end
      end
      ST_SEMI: begin
        cmd_o.sel = SEL_SEMI;
        if (free) begin
          cmd_o.push     = 1'b1;
          cmd_o.load_col = 1'b1;
          state_d        = ST_COL;
        end
      end
      ST_FIN: begin
        cmd_o.sel = SEL_H;
        if (free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives row and column words into the cursor sequence generator with random
// gaps on the input and random stalls on the output. Every output word is
// checked against typed text or a byte-level model of the cursor-position sequence:
// ESC, '[', the row in decimal, ';', the column in decimal, and then 'H'.
// ----------------------------------------------------------------------------
module testbench;
  import acsg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PAIRS = 100;
  localparam int QUIET_PAIRS = 15;

  // One directed row: a zero text means the model works out the sequence
  typedef struct packed {
    logic [31:0]  row;
    logic [31:0]  col;
    logic [191:0] text;
  } cursor_case_t;

  // One output word as it should appear on the master side
  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } seq_char_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [63:0] s_data = '0;
  logic        m_ready = 1'b0;
  wire         s_ready;
  wire         m_valid;
  wire  [7:0]  m_data;
  wire         m_last;

  seq_char_t   pending_chars[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          feed_idle = 1'b1;
  bit          sink_idle = 1'b1;
  bit          quiet = 1'b0;

  cursor_case_t directed_cases [0:21] = '{
    '{32'd0,          32'd0,          "\033[0;0H"},
    '{32'd1,          32'd1,          "\033[1;1H"},
    '{32'hFFFFFFFF,   32'hFFFFFFFF,   "\033[4294967295;4294967295H"},
    '{32'd0,          32'hFFFFFFFF,   "\033[0;4294967295H"},
    '{32'hFFFFFFFF,   32'd0,          "\033[4294967295;0H"},
    '{32'd9,          32'd10,         "\033[9;10H"},
    '{32'd99,         32'd100,        "\033[99;100H"},
    '{32'd999,        32'd1000,       "\033[999;1000H"},
    '{32'd9999,       32'd10000,      "\033[9999;10000H"},
    '{32'd99999,      32'd100000,     "\033[99999;100000H"},
    '{32'd999999,     32'd1000000,    "\033[999999;1000000H"},
    '{32'd9999999,    32'd10000000,   "\033[9999999;10000000H"},
    '{32'd99999999,   32'd100000000,  "\033[99999999;100000000H"},
    '{32'd999999999,  32'd1000000000, "\033[999999999;1000000000H"},
    '{32'd24,         32'd80,         "\033[24;80H"},
    '{32'd101,        32'd1010,       "\033[101;1010H"},
    '{32'd1000000000, 32'd0,          "\033[1000000000;0H"},
    '{32'd1000000001, 32'h80000000,   '0},
    '{32'h80000000,   32'h7FFFFFFF,   '0},
    '{32'hAAAAAAAA,   32'h55555555,   '0},
    '{32'h55555555,   32'hAAAAAAAA,   '0},
    '{32'd4000000000, 32'd3999999999, '0}
  };

  ansi_cursor_sequence_generator_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),    // [31:0] row, [63:32] column
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),    // [6:0] out_byte, [7] zero
    .m_axis_tlast_o  (m_last)     // last
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Append one character to the expected sequence
  function automatic void push_char(input logic [6:0] ch, input logic last);
    seq_char_t entry;
    entry.ch = ch;
    entry.last = last;
    pending_chars.push_back(entry);
  endfunction

  // Decimal digits of a value, leading zeros dropped, saturated to the places
  function automatic void push_decimal(input logic [31:0] value);
    int unsigned     digits;
    longint unsigned place;
    longint unsigned rest;
    longint unsigned digit;
    bit              begun;
    digits = (MAX_DIGITS < 1) ? 1 : ((MAX_DIGITS > 10) ? 10 : MAX_DIGITS);
    place = 1;
    for (int i = 1; i < digits; i++) place = place * 10;
    rest = value;
    if (rest > place * 10 - 1) rest = place * 10 - 1;
    begun = 1'b0;
    while (place != 0) begin
      digit = rest / place;
      rest = rest % place;
      if (digit != 0 || begun || place == 1) begin
        push_char(CH_ZERO + 7'(digit), 1'b0);
        begun = 1'b1;
      end
      place = place / 10;
    end
  endfunction

  // Full cursor-position sequence for one row and column pair
  function automatic void predict_cursor_seq(input logic [31:0] row, input logic [31:0] col);
    push_char(CH_ESC, 1'b0);
    push_char(CH_LBR, 1'b0);
    push_decimal(row);
    push_char(CH_SEMI, 1'b0);
    push_decimal(col);
    push_char(CH_H, 1'b1);
  endfunction

  // Expected sequence typed as text, leading zero bytes skipped
  function automatic void queue_typed(input logic [191:0] text);
    logic [7:0] ch;
    for (int i = 23; i >= 0; i--) begin
      ch = text[i*8 +: 8];
      if (ch != 8'd0) push_char(ch[6:0], i == 0);
    end
  endfunction

  // Number with a spread of decimal lengths and values near powers of ten
  function automatic logic [31:0] pick_number();
    longint unsigned p;
    p = 1;
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 9);
      1: return $urandom_range(0, 999);
      2: return $urandom_range(0, 999999);
      3: begin
        for (int k = $urandom_range(0, 9); k > 0; k--) p = p * 10;
        return 32'(p - 1 + $urandom_range(0, 2));
      end
      default: return $urandom;
    endcase
  endfunction

  // Offer one pair, hold it until taken, then record its sequence
  task automatic send_pair(input logic [31:0] row, input logic [31:0] col,
                           input logic [191:0] text);
    int unsigned gap;
    gap = 0;
    if (!quiet && feed_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {col, row};
    do @(negedge clk_i); while (!s_ready);
    if (text == '0) predict_cursor_seq(row, col);
    else queue_typed(text);
    @(posedge clk_i);
  endtask

  // Hold until every expected word has come out
  task automatic drain_sequences();
    s_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  // Stall the output side in random bursts
  always @(posedge clk_i) begin
    if ($urandom_range(0, 63) == 0) sink_idle <= ~sink_idle;
    if (stall_left != 0) begin
      m_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && sink_idle && $urandom_range(0, 5) == 0) begin
      m_ready <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      m_ready <= 1'b1;
    end
  end

  // Check each word taken at the coming edge against the oldest expectation
  always @(negedge clk_i) begin
    seq_char_t want;
    if (rst_n && m_valid && m_ready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: word with none expected: data %h last %b", $time, m_data, m_last);
        mismatch_count++;
      end else begin
        want = pending_chars.pop_front();
        if (m_data !== {1'b0, want.ch}) begin
          $display("%0t: data mismatch: expected %h actual %h", $time, {1'b0, want.ch}, m_data);
          mismatch_count++;
        end
        if (m_last !== want.last) begin
          $display("%0t: last mismatch: expected %b actual %b", $time, want.last, m_last);
          mismatch_count++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Reset, directed table, random pairs, then wait out the tail
  initial begin
    logic [31:0] row;
    logic [31:0] col;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 22; i++) begin
      send_pair(directed_cases[i].row, directed_cases[i].col, directed_cases[i].text);
    end
    drain_sequences();

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n % 20 == 0) feed_idle = ($urandom_range(0, 2) != 0);
      if (n == RANDOM_PAIRS / 2) drain_sequences();
      if (n == RANDOM_PAIRS - QUIET_PAIRS) quiet = 1'b1;
      row = pick_number();
      col = pick_number();
      send_pair(row, col, '0);
    end
    s_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
